/* hw/rtl/clf_pkg.sv */
// Shared types and constants of the CRLF line framer.
package clf_pkg;

	localparam int BYTE_W    = 8;
	localparam int CLASSIC_W = 16;
	localparam int TAG_W     = 14;
	localparam int FAULT_W   = 16;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DATA_W = BYTE_W + FAULT_W;

	// Short queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	// Register indexes of the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CLASSIC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TAG     = 2'd1;

	localparam logic [CLASSIC_W-1:0] MAX_CLASSIC_RST = 16'd512;
	localparam logic [TAG_W-1:0]     MAX_TAG_RST     = 14'd8191;

	// Result kinds
	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t K_BYTE     = 2'd0;
	localparam kind_t K_GOOD     = 2'd1;
	localparam kind_t K_INVALID  = 2'd2;
	localparam kind_t K_TOO_MANY = 2'd3;

	// Characters
	localparam logic [BYTE_W-1:0] CH_AT  = 8'h40;
	localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

	typedef struct packed {
		kind_t               kind;
		logic [BYTE_W-1:0]   line_byte;
		logic [FAULT_W-1:0]  fault_bytes;
	} res_t;

	// One queue entry: an optional flushed CR byte, then an optional main result
	typedef struct packed {
		logic has_cr;
		logic has_main;
		res_t main;
	} rec_t;

endpackage

/* hw/rtl/clf_front.sv */
// Front part: per-byte line state, length checks and result classification.
module clf_front import clf_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [BYTE_W-1:0]     rx_byte,
	input  logic [CLASSIC_W-1:0]  max_classic,
	input  logic [TAG_W-1:0]      max_tag,
	output logic                  push,
	output rec_t                  rec,
	output logic                  discarding
);

	localparam int LB = LENGTH_BITS;
	localparam int CW = ((LB > CLASSIC_W) ? LB : CLASSIC_W) + 2;
	localparam logic [LB:0] LEN_FULL = {1'b0, {LB{1'b1}}};

	logic [LB-1:0] len_q, sp_q;
	logic          tagged_q, space_q, cr_q, disc_q;

	logic [LB-1:0] len_d, sp_d, len_a, sp_n;
	logic          tagged_d, space_d, cr_d, disc_d;
	logic          tag_n, space_n, new_space;
	logic          cr_flush, lf_end, too_long, line_ok;
	logic [LB:0]   sz;
	logic [CW-1:0] szc, spc, lenc, clc, tgc;
	rec_t          rec_c;

	assign cr_flush  = cr_q && (rx_byte != CH_LF);
	assign lf_end    = cr_q && (rx_byte == CH_LF);
	assign len_a     = cr_flush ? len_q + LB'(1) : len_q;
	assign sz        = {1'b0, len_a} + (LB+1)'(1);
	assign tag_n     = tagged_q || ((len_a == '0) && (rx_byte == CH_AT));
	assign new_space = !space_q && (rx_byte == CH_SP);
	assign space_n   = space_q || new_space;
	assign sp_n      = new_space ? len_a : sp_q;

	assign szc  = CW'(sz);
	assign spc  = CW'(sp_n);
	assign lenc = CW'(len_q);
	assign clc  = CW'(max_classic);
	assign tgc  = CW'(max_tag);

	// Open line check on the buffered size with the new byte
	always_comb begin
		if (sz >= LEN_FULL) begin
			too_long = 1'b1;
		end else if (!tag_n) begin
			too_long = szc >= clc;
		end else if (!space_n) begin
			too_long = szc > tgc + CW'(1);
		end else begin
			too_long = (sp_n == '0) || (spc - CW'(1) > tgc) ||
				(szc - spc - CW'(1) >= clc);
		end
	end

	// Finished line check at CR LF, uses the committed line state
	always_comb begin
		if (!tagged_q || !space_q) begin
			line_ok = lenc + CW'(2) <= clc;
		end else begin
			line_ok = (sp_q != '0) && (CW'(sp_q) - CW'(1) <= tgc) &&
				(lenc - CW'(sp_q) + CW'(1) <= clc);
		end
	end

	always_comb begin
		rec_c          = '0;
		len_d          = len_q;
		sp_d           = sp_q;
		tagged_d       = tagged_q;
		space_d        = space_q;
		cr_d           = cr_q;
		disc_d         = disc_q;
		if (disc_q) begin
			if (lf_end) begin
				disc_d = 1'b0;
				cr_d   = 1'b0;
			end else begin
				cr_d = (rx_byte == CH_CR);
			end
		end else if (lf_end) begin
			rec_c.has_main = 1'b1;
			if (line_ok) begin
				rec_c.main.kind = K_GOOD;
			end else begin
				rec_c.main.kind        = K_TOO_MANY;
				rec_c.main.fault_bytes = FAULT_W'(len_q);
			end
			len_d    = '0;
			sp_d     = '0;
			tagged_d = 1'b0;
			space_d  = 1'b0;
			cr_d     = 1'b0;
		end else begin
			rec_c.has_cr = cr_flush;
			len_d        = len_a;
			if (rx_byte == CH_NUL) begin
				rec_c.has_main         = 1'b1;
				rec_c.main.kind        = K_INVALID;
				rec_c.main.fault_bytes = FAULT_W'(sz);
				cr_d                   = 1'b0;
				disc_d                 = 1'b1;
			end else begin
				cr_d = (rx_byte == CH_CR);
				if (too_long) begin
					rec_c.has_main         = 1'b1;
					rec_c.main.kind        = K_TOO_MANY;
					rec_c.main.fault_bytes = FAULT_W'(sz);
					disc_d                 = 1'b1;
				end else if (rx_byte != CH_CR) begin
					rec_c.has_main       = 1'b1;
					rec_c.main.kind      = K_BYTE;
					rec_c.main.line_byte = rx_byte;
					len_d                = sz[LB-1:0];
					tagged_d             = tag_n;
					space_d              = space_n;
					sp_d                 = sp_n;
				end
			end
			// Any abort clears the line
			if (disc_d) begin
				len_d    = '0;
				sp_d     = '0;
				tagged_d = 1'b0;
				space_d  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			sp_q     <= '0;
			tagged_q <= 1'b0;
			space_q  <= 1'b0;
			cr_q     <= 1'b0;
			disc_q   <= 1'b0;
		end else if (take) begin
			len_q    <= len_d;
			sp_q     <= sp_d;
			tagged_q <= tagged_d;
			space_q  <= space_d;
			cr_q     <= cr_d;
			disc_q   <= disc_d;
		end
	end

	assign push       = take && (rec_c.has_cr || rec_c.has_main);
	assign rec        = rec_c;
	assign discarding = disc_q;

endmodule

/* hw/rtl/clf_queue.sv */
// Short queue of classified records between front and back.
module clf_queue import clf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	input  logic pop,
	output rec_t head,
	output logic empty,
	output logic full,
	output logic [Q_CNT_W-1:0] count
);

	rec_t               mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q, rptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push, do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rptr_q];
	assign count   = cnt_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + Q_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/clf_back.sv */
// Back part: unpacks queue records into single results behind an output register.
module clf_back import clf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rec_t                   head,
	input  logic                   empty,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output res_t                   out_res,
	output logic                   out_last
);

	logic valid_q, last_q, cr_done_q, load, emit_cr;
	res_t res_q;

	assign load    = !valid_q || out_ready;
	assign emit_cr = head.has_cr && !cr_done_q;
	// Pop once the last piece of the head record goes into the output register
	assign pop     = load && !empty && (!emit_cr || !head.has_main);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			cr_done_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				cr_done_q <= emit_cr && head.has_main;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			if (emit_cr) begin
				res_q.kind        <= K_BYTE;
				res_q.line_byte   <= CH_CR;
				res_q.fault_bytes <= '0;
				last_q            <= !head.has_main;
			end else begin
				res_q  <= head.main;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;
	assign out_last  = last_q;

endmodule

/* hw/rtl/crlf_line_framer_length_check.sv */
// Top level of the CRLF line framer with classic and tag-section length checks.
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+--------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | tdata: rx_byte
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata: line_byte, fault_bytes;
//            |           |                                | tuser: kind; tlast: last
//  cfg       | in        | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// The front classifies one byte per cycle while the queue has room and writes at most one
// record into a four-entry queue; the back drains one result per cycle. A byte that flushes
// a held CR and gives a result of its own yields the CR byte, then its own result, others
// one or none. Each result passes the queue, then the output register. Reset (arst_n low)
// clears line state, queue and output register and loads the limits with 512 and 8191. A
// stall on m_axis fills the queue; s_axis_tready drops only when the queue is full.
module crlf_line_framer_length_check import clf_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// rx byte stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] rx_byte
	// framed results
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [7:0] line_byte, [23:8] fault_bytes
	output logic [KIND_W-1:0]      m_axis_tuser,   // [1:0] kind
	output logic                   m_axis_tlast,   // last
	// limit register writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [CLASSIC_W-1:0] max_classic_q;
	logic [TAG_W-1:0]     max_tag_q;
	logic                 take, push, pop, q_empty, q_full, discarding;
	logic [Q_CNT_W-1:0]   q_count;
	rec_t                 push_rec, head;
	res_t                 out_res;

	// Limit registers: writes are always taken, unknown indexes drop silently
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_classic_q <= MAX_CLASSIC_RST;
			max_tag_q     <= MAX_TAG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_CLASSIC: max_classic_q <= cfg_data[CLASSIC_W-1:0];
				REG_MAX_TAG:     max_tag_q     <= cfg_data[TAG_W-1:0];
				default: ;
			endcase
		end
	end

	// Accept a byte whenever the queue has room for its record
	assign s_axis_tready = !q_full;
	assign take          = s_axis_tvalid && s_axis_tready;

	clf_front #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.rx_byte     (s_axis_tdata),
		.max_classic (max_classic_q),
		.max_tag     (max_tag_q),
		.push        (push),
		.rec         (push_rec),
		.discarding  (discarding)
	);

	clf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full),
		.count    (q_count)
	);

	clf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {out_res.fault_bytes, out_res.line_byte};
	assign m_axis_tuser = out_res.kind;

	// A record is pushed only when the queue can hold it
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_count < Q_CNT_W'(Q_DEPTH)))
		else $error("record pushed into a full queue");

	// A NUL byte on an open line starts a discard
	a_nul_discards: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !discarding && (s_axis_tdata == CH_NUL)) |=> discarding)
		else $error("NUL byte did not start a discard");

	// End markers and aborts always close the results of their byte
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != K_BYTE)) |-> m_axis_tlast)
		else $error("end or abort marker without last");

	// Nothing is queued while dropping bytes
	a_quiet_discard: assert property (@(posedge clk) disable iff (!arst_n)
		(take && discarding) |-> !push)
		else $error("result produced while discarding");

endmodule
